// ===== hw/rtl/rgb_histogram_with_peak_top_macros.svh =====
// ----------------------------------------------------------------------------
// RGB histogram assertion macros
// Shared concurrent assertion forms used by the histogram block.
// ----------------------------------------------------------------------------
`ifndef RGB_HISTOGRAM_WITH_PEAK_TOP_MACROS_SVH
`define RGB_HISTOGRAM_WITH_PEAK_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGBH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rgbh_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB histogram package
// Sizes, operation codes and command types shared by the histogram modules.
// ----------------------------------------------------------------------------
package rgbh_pkg;

    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 24;
    localparam int BIN_BITS   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int OUT_BITS   = 24;
    localparam int CHANNELS   = 3;
    localparam int EN_BITS    = 3;

    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [EN_BITS-1:0] ENABLE_RESET = 3'd7;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic load_item;
        logic read_mem;
        logic update;
        logic clear_step;
        logic load_out;
    } t_dp_cmd;

    function automatic logic [OUT_BITS-1:0] to_out(input t_count c);
        logic [31:0] w;
        w = 32'(c);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/rgbh_in_if.sv =====
// ----------------------------------------------------------------------------
// RGB histogram input channel
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface rgbh_in_if;

    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] pixel;
    logic [7:0]  bin_index;

    modport source (output valid, output op, output pixel, output bin_index, input ready);
    modport sink (input valid, input op, input pixel, input bin_index, output ready);

endinterface

// ===== hw/rtl/rgbh_out_if.sv =====
// ----------------------------------------------------------------------------
// RGB histogram result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface rgbh_out_if;

    logic        valid;
    logic        ready;
    logic [23:0] red_count;
    logic [23:0] green_count;
    logic [23:0] blue_count;
    logic [23:0] red_peak;
    logic [23:0] green_peak;
    logic [23:0] blue_peak;
    logic [23:0] overall_peak;

    modport source (
        output valid, output red_count, output green_count, output blue_count,
        output red_peak, output green_peak, output blue_peak, output overall_peak,
        input ready
    );
    modport sink (
        input valid, input red_count, input green_count, input blue_count,
        input red_peak, input green_peak, input blue_peak, input overall_peak,
        output ready
    );

endinterface

// ===== hw/rtl/rgbh_ctrl.sv =====
// ----------------------------------------------------------------------------
// RGB histogram controller
// Sequences each word through bin read, update, a clearing pass for clear words, and result load.
// ----------------------------------------------------------------------------
`include "rgb_histogram_with_peak_top_macros.svh"

module rgbh_ctrl
    import rgbh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  logic    i_is_clear,
    input  logic    i_clr_last,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_UPDATE = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.clear_step = 1'b1;
                if (i_clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read_mem = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = i_is_clear ? S_CLEAR : S_DONE;
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `RGBH_ASSERT_NEXT(a_accept_starts_read, w_accept, r_state == S_READ, "accept did not start read")
    `RGBH_ASSERT_SAME(a_no_overwrite, o_cmd.load_out, !r_out_valid || i_out_ready, "result overwritten")
    `RGBH_ASSERT_NEXT(a_result_held, r_out_valid && !i_out_ready, r_out_valid, "pending result lost")
    `RGBH_ASSERT_SAME(a_state_onehot, 1'b1, $onehot(r_state), "state not one-hot")
    `RGBH_ASSERT_SAME(a_clear_no_accept, o_cmd.clear_step, !o_in_ready, "accept during clear pass")

endmodule

// ===== hw/rtl/rgbh_datapath.sv =====
// ----------------------------------------------------------------------------
// RGB histogram datapath
// Bin memories, per-channel peaks, channel enable and result registers.
// ----------------------------------------------------------------------------
module rgbh_datapath
    import rgbh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [EN_BITS-1:0]  i_cfg_wdata,
    input  t_dp_cmd             i_cmd,
    input  logic [1:0]          i_op,
    input  logic [31:0]         i_pixel,
    input  logic [7:0]          i_bin_index,
    output logic                o_is_clear,
    output logic                o_clr_last,
    output logic [OUT_BITS-1:0] o_red_count,
    output logic [OUT_BITS-1:0] o_green_count,
    output logic [OUT_BITS-1:0] o_blue_count,
    output logic [OUT_BITS-1:0] o_red_peak,
    output logic [OUT_BITS-1:0] o_green_peak,
    output logic [OUT_BITS-1:0] o_blue_peak,
    output logic [OUT_BITS-1:0] o_overall_peak
);

    logic [1:0]           r_op;
    logic [23:0]          r_pixel;
    logic [7:0]           r_idx;
    logic [EN_BITS-1:0]   r_enable;
    logic [BIN_BITS-1:0]  r_clr_addr;

    t_count               r_mem   [CHANNELS][BIN_COUNT];
    t_count               r_rd    [CHANNELS];
    t_count               r_peak  [CHANNELS];
    t_count               r_cnt   [CHANNELS];

    logic [7:0]           w_val   [CHANNELS];
    logic [7:0]           w_addr  [CHANNELS];
    logic [BIN_BITS-1:0]  w_row   [CHANNELS];
    logic                 w_in_range [CHANNELS];
    t_count               w_cur   [CHANNELS];
    t_count               w_inc   [CHANNELS];
    t_count               w_overall;
    logic                 w_clr_last;

    logic [OUT_BITS-1:0]  r_o_cnt  [CHANNELS];
    logic [OUT_BITS-1:0]  r_o_peak [CHANNELS];
    logic [OUT_BITS-1:0]  r_o_overall;

    assign w_val[CH_RED]   = r_pixel[23:16];
    assign w_val[CH_GREEN] = r_pixel[15:8];
    assign w_val[CH_BLUE]  = r_pixel[7:0];

    assign w_clr_last = (r_clr_addr == BIN_BITS'(BIN_COUNT - 1));
    assign o_clr_last = w_clr_last;
    assign o_is_clear = (r_op == OP_CLEAR);

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_addr[c]     = (r_op == OP_READ) ? r_idx : w_val[c];
            w_row[c]      = w_addr[c][BIN_BITS-1:0];
            w_in_range[c] = ({1'b0, w_addr[c]} < 9'(BIN_COUNT));
            w_cur[c]      = w_in_range[c] ? r_rd[c] : '0;
            w_inc[c]      = (w_cur[c] == '1) ? w_cur[c] : w_cur[c] + 1'b1;
        end
    end

    always_comb begin
        w_overall = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_enable[c] && (r_peak[c] > w_overall)) begin
                w_overall = r_peak[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_op;
            r_pixel <= i_pixel[23:0];
            r_idx   <= i_bin_index;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (i_cmd.read_mem) begin
                r_rd[c] <= r_mem[c][w_row[c]];
            end
            if (i_cmd.clear_step) begin
                r_mem[c][r_clr_addr] <= '0;
            end else if (i_cmd.update && (r_op == OP_PIXEL) && w_in_range[c]) begin
                r_mem[c][w_row[c]] <= w_inc[c];
            end
            if (i_cmd.update) begin
                r_cnt[c] <= (r_op == OP_READ) ? w_cur[c] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= ENABLE_RESET;
            r_clr_addr <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_peak[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (i_cmd.clear_step) begin
                r_clr_addr <= w_clr_last ? '0 : r_clr_addr + 1'b1;
            end
            for (int c = 0; c < CHANNELS; c++) begin
                if (i_cmd.update) begin
                    if ((r_op == OP_PIXEL) && w_in_range[c]) begin
                        if (w_inc[c] > r_peak[c]) begin
                            r_peak[c] <= w_inc[c];
                        end
                    end else if (r_op == OP_CLEAR) begin
                        r_peak[c] <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_o_cnt[c]  <= to_out(r_cnt[c]);
                r_o_peak[c] <= to_out(r_peak[c]);
            end
            r_o_overall <= to_out(w_overall);
        end
    end

    assign o_red_count    = r_o_cnt[CH_RED];
    assign o_green_count  = r_o_cnt[CH_GREEN];
    assign o_blue_count   = r_o_cnt[CH_BLUE];
    assign o_red_peak     = r_o_peak[CH_RED];
    assign o_green_peak   = r_o_peak[CH_GREEN];
    assign o_blue_peak    = r_o_peak[CH_BLUE];
    assign o_overall_peak = r_o_overall;

endmodule

// ===== hw/rtl/rgb_histogram_with_peak_top.sv =====
// ----------------------------------------------------------------------------
// RGB histogram with peak, top level
// A word steps through read, update and done; the next is taken only after its result loads.
// A clear word adds a pass over all bins that zeroes one bin address per cycle in each memory.
// Synchronous active-low reset zeroes peaks and handshakes, then runs the same clearing pass.
// ----------------------------------------------------------------------------
module rgb_histogram_with_peak_top
    import rgbh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [EN_BITS-1:0] i_cfg_wdata,
    rgbh_in_if.sink            i_pix,
    rgbh_out_if.source         o_res
);

    t_dp_cmd w_cmd;
    logic    w_is_clear;
    logic    w_clr_last;

    rgbh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_is_clear  (w_is_clear),
        .i_clr_last  (w_clr_last),
        .o_cmd       (w_cmd)
    );

    rgbh_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (w_cmd),
        .i_op           (i_pix.op),
        .i_pixel        (i_pix.pixel),
        .i_bin_index    (i_pix.bin_index),
        .o_is_clear     (w_is_clear),
        .o_clr_last     (w_clr_last),
        .o_red_count    (o_res.red_count),
        .o_green_count  (o_res.green_count),
        .o_blue_count   (o_res.blue_count),
        .o_red_peak     (o_res.red_peak),
        .o_green_peak   (o_res.green_peak),
        .o_blue_peak    (o_res.blue_peak),
        .o_overall_peak (o_res.overall_peak)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB histogram with peak testbench
// Sends pixel, read, clear and unused-code words through randomly paced
// valid/ready channels and predicts every result word from a local copy of
// the bins, peaks and channel enable. Each result field is checked in order.
// ----------------------------------------------------------------------------
module tb;
    import rgbh_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int RANDOM_CHUNKS = 10;
    localparam int CHUNK_WORDS   = 100;
    localparam int ENABLE_WORDS  = 20;

    localparam int READY_ALWAYS  = 0;
    localparam int READY_COIN    = 1;
    localparam int READY_MOSTLY  = 2;
    localparam int READY_BLOCKED = 3;

    typedef struct packed {
        logic [OUT_BITS-1:0] red_count;
        logic [OUT_BITS-1:0] green_count;
        logic [OUT_BITS-1:0] blue_count;
        logic [OUT_BITS-1:0] red_peak;
        logic [OUT_BITS-1:0] green_peak;
        logic [OUT_BITS-1:0] blue_peak;
        logic [OUT_BITS-1:0] overall_peak;
    } t_hist_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [EN_BITS-1:0] i_cfg_wdata;

    rgbh_in_if  pix_ch();
    rgbh_out_if res_ch();

    t_count             bin_counts [CHANNELS][BIN_COUNT];
    t_count             peak_counts [CHANNELS];
    logic [EN_BITS-1:0] enable_model;
    t_hist_result       pending_results [$];
    t_hist_result       oldest_result;

    int errors      = 0;
    int cycles      = 0;
    int burst_left  = 0;
    int ready_left  = 0;
    int ready_mode  = READY_ALWAYS;

    rgb_histogram_with_peak_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_ch),
        .o_res       (res_ch)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void clear_histograms();
        for (int c = 0; c < CHANNELS; c++) begin
            peak_counts[c] = '0;
            for (int b = 0; b < BIN_COUNT; b++) begin
                bin_counts[c][b] = '0;
            end
        end
    endfunction

    function automatic void count_level(input int ch, input logic [7:0] level);
        if (level < BIN_COUNT) begin
            if (bin_counts[ch][level] != '1) begin
                bin_counts[ch][level] = bin_counts[ch][level] + 1'b1;
            end
            if (bin_counts[ch][level] > peak_counts[ch]) begin
                peak_counts[ch] = bin_counts[ch][level];
            end
        end
    endfunction

    function automatic t_hist_result histogram_step(input logic [1:0] op,
                                                    input logic [31:0] pixel,
                                                    input logic [7:0] bin);
        t_hist_result r;
        t_count       overall;
        r = '0;
        overall = '0;
        case (op)
            OP_PIXEL: begin
                count_level(CH_BLUE, pixel[7:0]);
                count_level(CH_GREEN, pixel[15:8]);
                count_level(CH_RED, pixel[23:16]);
            end
            OP_READ: begin
                if (bin < BIN_COUNT) begin
                    r.red_count   = bin_counts[CH_RED][bin];
                    r.green_count = bin_counts[CH_GREEN][bin];
                    r.blue_count  = bin_counts[CH_BLUE][bin];
                end
            end
            OP_CLEAR: begin
                clear_histograms();
            end
            default: begin
            end
        endcase
        for (int c = 0; c < CHANNELS; c++) begin
            if (enable_model[c] && peak_counts[c] > overall) begin
                overall = peak_counts[c];
            end
        end
        r.red_peak     = peak_counts[CH_RED];
        r.green_peak   = peak_counts[CH_GREEN];
        r.blue_peak    = peak_counts[CH_BLUE];
        r.overall_peak = overall;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [OUT_BITS-1:0] want,
                               input logic [OUT_BITS-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word arrived with no expectation pending");
                errors++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("red_count", oldest_result.red_count, res_ch.red_count);
                check_field("green_count", oldest_result.green_count, res_ch.green_count);
                check_field("blue_count", oldest_result.blue_count, res_ch.blue_count);
                check_field("red_peak", oldest_result.red_peak, res_ch.red_peak);
                check_field("green_peak", oldest_result.green_peak, res_ch.green_peak);
                check_field("blue_peak", oldest_result.blue_peak, res_ch.blue_peak);
                check_field("overall_peak", oldest_result.overall_peak, res_ch.overall_peak);
            end
        end
    end

    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(READY_ALWAYS, READY_BLOCKED);
            ready_left = (ready_mode == READY_BLOCKED) ? $urandom_range(1, 12)
                                                       : $urandom_range(4, 40);
        end
        ready_left--;
        case (ready_mode)
            READY_ALWAYS: res_ch.ready <= 1'b1;
            READY_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
            READY_MOSTLY: res_ch.ready <= ($urandom_range(0, 3) != 0);
            default:      res_ch.ready <= 1'b0;
        endcase
    end

    task automatic send_word(input logic [1:0] op, input logic [31:0] pixel,
                             input logic [7:0] bin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            repeat (gap) begin
                @(negedge i_clk);
                pix_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        pix_ch.valid     <= 1'b1;
        pix_ch.op        <= op;
        pix_ch.pixel     <= pixel;
        pix_ch.bin_index <= bin;
        @(posedge i_clk);
        while (!pix_ch.ready) begin
            @(posedge i_clk);
        end
        pending_results.insert(pending_results.size(), histogram_step(op, pixel, bin));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic [EN_BITS-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        enable_model = value;
    endtask

    function automatic logic [7:0] hot_level();
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(252, 255));
    endfunction

    function automatic logic [31:0] random_pixel();
        logic [31:0] p;
        p = $urandom();
        if ($urandom_range(0, 1)) begin
            p[23:0] = {hot_level(), hot_level(), hot_level()};
        end
        return p;
    endfunction

    task automatic send_random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            send_word(OP_PIXEL, random_pixel(), 8'($urandom()));
        end else if (pick < 92) begin
            send_word(OP_READ, $urandom(),
                      $urandom_range(0, 1) ? hot_level() : 8'($urandom()));
        end else if (pick < 93) begin
            send_word(OP_CLEAR, $urandom(), 8'($urandom()));
        end else begin
            send_word(OP_UNUSED, random_pixel(), 8'($urandom()));
        end
    endtask

    task automatic test_reset_state();
        send_word(OP_READ, 32'h0000_0000, 8'h00);
        send_word(OP_READ, 32'hFFFF_FFFF, 8'hFF);
        send_word(OP_READ, 32'h0000_0000, 8'h80);
        send_word(OP_UNUSED, 32'h0000_0000, 8'h00);
    endtask

    task automatic test_directed_ops();
        send_word(OP_PIXEL, 32'h0000_0000, 8'h00);
        send_word(OP_PIXEL, 32'hFFFF_FFFF, 8'hFF);
        send_word(OP_PIXEL, 32'h80FF_0000, 8'h00);
        send_word(OP_PIXEL, 32'h0000_FF00, 8'h00);
        send_word(OP_PIXEL, 32'h0000_00FF, 8'h00);
        send_word(OP_PIXEL, 32'h7F01_0203, 8'h00);
        send_word(OP_PIXEL, 32'hFF01_0203, 8'h00);
        send_word(OP_PIXEL, 32'h0001_0203, 8'h00);
        send_word(OP_READ, 32'h0000_0000, 8'h00);
        send_word(OP_READ, 32'h0000_0000, 8'hFF);
        send_word(OP_READ, 32'h0000_0000, 8'h01);
        send_word(OP_READ, 32'h0000_0000, 8'h03);
        send_word(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);
        send_word(OP_CLEAR, 32'h0000_0000, 8'h00);
        send_word(OP_READ, 32'h0000_0000, 8'hFF);
        send_word(OP_READ, 32'h0000_0000, 8'h03);
        send_word(OP_PIXEL, 32'h00AA_55AA, 8'h00);
        send_word(OP_READ, 32'h0000_0000, 8'hAA);
        send_word(OP_READ, 32'h0000_0000, 8'h55);
    endtask

    task automatic test_channel_enable();
        logic [EN_BITS-1:0] settings [8];
        settings = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7};
        foreach (settings[s]) begin
            write_enable(settings[s]);
            repeat (ENABLE_WORDS) send_random_word();
        end
    endtask

    task automatic test_random_traffic();
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            repeat (CHUNK_WORDS) send_random_word();
            write_enable(EN_BITS'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        pix_ch.valid     = 1'b0;
        pix_ch.op        = OP_PIXEL;
        pix_ch.pixel     = '0;
        pix_ch.bin_index = '0;
        res_ch.ready     = 1'b0;
        clear_histograms();
        enable_model = ENABLE_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed_ops();
        test_channel_enable();
        test_random_traffic();
        wait_idle();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
